/* hw/rtl/pgv_pkg.sv */
// Shared types and constants for the planar proportional-gain velocity step.
package pgv_pkg;

  // Half and full turn in Q16.16 radians.
  localparam logic signed [21:0] PI_Q16     = 22'sd205887;
  localparam logic signed [21:0] TWO_PI_Q16 = 22'sd411775;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FRAME_PERIOD    = 3'd0;
  localparam logic [2:0] REG_LINEAR_GAIN     = 3'd1;
  localparam logic [2:0] REG_TURN_GAIN       = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT     = 3'd3;
  localparam logic [2:0] REG_TURN_RATE_LIMIT = 3'd4;

  // Register reset values.
  localparam logic [15:0] FRAME_PERIOD_RST    = 16'd655;
  localparam logic [23:0] LINEAR_GAIN_RST     = 24'd65536;
  localparam logic [23:0] TURN_GAIN_RST       = 24'd65536;
  localparam logic [30:0] SPEED_LIMIT_RST     = 31'd65536;
  localparam logic [30:0] TURN_RATE_LIMIT_RST = 31'd205887;

  // One command transaction.
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [19:0] start_heading;
    logic signed [31:0] start_vel_x;
    logic signed [31:0] start_vel_y;
    logic signed [31:0] start_turn_rate;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [19:0] target_heading;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] turn_rate;
    logic               last_step;
  } res_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [19:0] start_heading;
    logic signed [31:0] start_vel_x;
    logic signed [31:0] start_vel_y;
    logic signed [31:0] start_turn_rate;
    logic               vx_neg;
    logic [40:0]        vx_mag;
    logic               vy_neg;
    logic [40:0]        vy_mag;
    logic signed [31:0] vw;
    logic               over;
  } job_t;

endpackage

/* hw/rtl/planar_p_gain_velocity_step.sv */
// Top level: configuration registers, command queue, front end and back end.
// A command enters a three-stage front end that forms errors, gain products
// and the speed-limit test, then waits in a short queue for the back end,
// which emits the echoed start and the advanced step into a result queue.
// A command within the speed limit goes straight to the frame step in the back
// end; one that must be scaled first passes through normalizing right shifts,
// the bit-serial square root and the bit-serial divide. Commands are taken
// every cycle while the queue has room.
module planar_p_gain_velocity_step #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int RESULT_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  pgv_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output pgv_pkg::res_t res,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import pgv_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int RCW = $clog2(RESULT_DEPTH + 1);

  logic [15:0] frame_period;
  logic [23:0] linear_gain;
  logic [23:0] turn_gain;
  logic [30:0] speed_limit;
  logic [30:0] turn_rate_limit;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period    <= FRAME_PERIOD_RST;
      linear_gain     <= LINEAR_GAIN_RST;
      turn_gain       <= TURN_GAIN_RST;
      speed_limit     <= SPEED_LIMIT_RST;
      turn_rate_limit <= TURN_RATE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_PERIOD:    frame_period    <= pwdata[15:0];
        REG_LINEAR_GAIN:     linear_gain     <= pwdata[23:0];
        REG_TURN_GAIN:       turn_gain       <= pwdata[23:0];
        REG_SPEED_LIMIT:     speed_limit     <= pwdata[30:0];
        REG_TURN_RATE_LIMIT: turn_rate_limit <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_PERIOD:    prdata = {16'd0, frame_period};
      REG_LINEAR_GAIN:     prdata = {8'd0, linear_gain};
      REG_TURN_GAIN:       prdata = {8'd0, turn_gain};
      REG_SPEED_LIMIT:     prdata = {1'b0, speed_limit};
      REG_TURN_RATE_LIMIT: prdata = {1'b0, turn_rate_limit};
      default:             prdata = 32'd0;
    endcase
  end

  logic           accept;
  logic           f_valid;
  job_t           f_job;
  logic [1:0]     f_busy;
  logic           q_full, q_empty, q_pop;
  logic [QCW-1:0] q_count;
  logic [$bits(job_t)-1:0] q_dout;
  logic [QCW:0]   q_used;
  logic           r_full, r_push;
  res_t           b_res;
  logic [RCW-1:0] r_count;
  logic [$bits(res_t)-1:0] r_dout;

  // Commands in the front end hold a reserved queue slot.
  assign q_used = {1'b0, q_count} + (QCW + 1)'(f_busy);
  assign full   = (q_used >= (QCW + 1)'(QUEUE_DEPTH));
  assign accept = push && !full;

  pgv_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (accept),
    .cmd             (cmd),
    .linear_gain     (linear_gain),
    .turn_gain       (turn_gain),
    .speed_limit     (speed_limit),
    .turn_rate_limit (turn_rate_limit),
    .out_valid       (f_valid),
    .job             (f_job),
    .busy            (f_busy)
  );

  pgv_fifo #(.WIDTH($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  pgv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!q_empty),
    .job          (job_t'(q_dout)),
    .q_pop        (q_pop),
    .frame_period (frame_period),
    .speed_limit  (speed_limit),
    .out_full     (r_full),
    .out_push     (r_push),
    .res          (b_res)
  );

  pgv_fifo #(.WIDTH($bits(res_t)), .DEPTH(RESULT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (b_res),
    .full  (r_full),
    .pop   (pop),
    .dout  (r_dout),
    .empty (empty),
    .count (r_count)
  );

  assign res = res_t'(r_dout);

  // The front end never delivers a job the queue cannot hold.
  a_no_q_overflow: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> !q_full)
    else $error("job queue overflow");

  // Reserved slots never exceed the queue depth.
  a_credit: assert property (@(posedge clk) disable iff (rst)
    q_used <= (QCW + 1)'(QUEUE_DEPTH))
    else $error("queue reservation exceeds depth");

  // The result queue never drops a result.
  a_res_count: assert property (@(posedge clk) disable iff (rst)
    (r_push && r_full) |=> (r_count == $past(r_count) || $past(pop)))
    else $error("result pushed into full queue");
endmodule

/* hw/rtl/pgv_fifo.sv */
// Small register-based first-in first-out queue.
module pgv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

/* hw/rtl/pgv_front.sv */
// Front end: error terms, gain products and speed-limit classification.
module pgv_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  pgv_pkg::cmd_t cmd,
  input  logic [23:0]   linear_gain,
  input  logic [23:0]   turn_gain,
  input  logic [30:0]   speed_limit,
  input  logic [30:0]   turn_rate_limit,
  output logic          out_valid,
  output pgv_pkg::job_t job,
  output logic [1:0]    busy
);
  import pgv_pkg::*;

  // Stage 1 registers.
  logic              v1;
  cmd_t              c1;
  logic [32:0]       ex1;
  logic [32:0]       ey1;
  logic signed [21:0] dth1;

  // Stage 2 registers.
  logic        v2;
  cmd_t        c2;
  logic        xneg2, yneg2, wneg2;
  logic [40:0] ux2, uy2;
  logic [29:0] wm2;

  // Stage 3 registers.
  logic v3;
  job_t j3;

  // Stage 1 logic: position errors and wrapped heading error.
  logic signed [21:0] d0, d1, d2;
  always_comb begin
    d0 = {{2{cmd.target_heading[19]}}, cmd.target_heading}
       - {{2{cmd.start_heading[19]}}, cmd.start_heading};
    d1 = (d0 < -PI_Q16) ? d0 + TWO_PI_Q16 : d0;
    d2 = (d1 > PI_Q16) ? d1 - TWO_PI_Q16 : d1;
  end

  always_ff @(posedge clk) begin
    c1   <= cmd;
    ex1  <= {cmd.target_x[31], cmd.target_x} - {cmd.start_x[31], cmd.start_x};
    ey1  <= {cmd.target_y[31], cmd.target_y} - {cmd.start_y[31], cmd.start_y};
    dth1 <= d2;
  end

  // Stage 2 logic: gain products rounded half away from zero.
  logic [32:0] exm, eym;
  logic [21:0] dm;
  logic [56:0] px, py;
  logic [45:0] pw;
  always_comb begin
    exm = ex1[32] ? (~ex1 + 33'd1) : ex1;
    eym = ey1[32] ? (~ey1 + 33'd1) : ey1;
    dm  = dth1[21] ? (~dth1 + 22'd1) : dth1;
    px  = 57'(exm) * 57'(linear_gain) + 57'd32768;
    py  = 57'(eym) * 57'(linear_gain) + 57'd32768;
    pw  = 46'(dm) * 46'(turn_gain) + 46'd32768;
  end

  always_ff @(posedge clk) begin
    c2    <= c1;
    xneg2 <= ex1[32];
    yneg2 <= ey1[32];
    wneg2 <= dth1[21];
    ux2   <= px[56:16];
    uy2   <= py[56:16];
    wm2   <= pw[45:16];
  end

  // Stage 3 logic: exact speed test and turn rate clamp.
  logic [61:0] sqx, sqy, sql;
  logic [62:0] sqs;
  logic        over3;
  logic [30:0] wc;
  always_comb begin
    sqx   = 62'(ux2[30:0]) * 62'(ux2[30:0]);
    sqy   = 62'(uy2[30:0]) * 62'(uy2[30:0]);
    sql   = 62'(speed_limit) * 62'(speed_limit);
    sqs   = 63'(sqx) + 63'(sqy);
    over3 = (ux2 > 41'(speed_limit)) || (uy2 > 41'(speed_limit)) || (sqs > 63'(sql));
    wc    = (31'(wm2) > turn_rate_limit) ? turn_rate_limit : 31'(wm2);
  end

  always_ff @(posedge clk) begin
    j3.start_x         <= c2.start_x;
    j3.start_y         <= c2.start_y;
    j3.start_heading   <= c2.start_heading;
    j3.start_vel_x     <= c2.start_vel_x;
    j3.start_vel_y     <= c2.start_vel_y;
    j3.start_turn_rate <= c2.start_turn_rate;
    j3.vx_neg          <= xneg2;
    j3.vx_mag          <= ux2;
    j3.vy_neg          <= yneg2;
    j3.vy_mag          <= uy2;
    j3.vw              <= wneg2 ? -{1'b0, wc} : {1'b0, wc};
    j3.over            <= over3;
  end

  // Valid bits for the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;
  assign job       = j3;
  assign busy      = 2'(v1) + 2'(v2) + 2'(v3);
endmodule

/* hw/rtl/pgv_back.sv */
// Back end: vector scaling by root and divide, frame step and result emit.
module pgv_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  pgv_pkg::job_t job,
  output logic          q_pop,
  input  logic [15:0]   frame_period,
  input  logic [30:0]   speed_limit,
  input  logic          out_full,
  output logic          out_push,
  output pgv_pkg::res_t res
);
  import pgv_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_NORM  = 10'b0000000010,
    ST_SQ    = 10'b0000000100,
    ST_ROOT  = 10'b0000001000,
    ST_SCALE = 10'b0000010000,
    ST_DIV   = 10'b0000100000,
    ST_FRAME = 10'b0001000000,
    ST_SUM   = 10'b0010000000,
    ST_EMIT0 = 10'b0100000000,
    ST_EMIT1 = 10'b1000000000
  } state_t;

  state_t state, state_next;

  job_t        jb;
  logic [40:0] a, b;
  logic [63:0] v, r, bitr;
  logic [4:0]  cnt;
  logic [32:0] rema, remb;
  logic [30:0] dla, dlb, qa, qb;
  logic signed [31:0] vxr, vyr;
  logic [31:0] dxm, dym, dwm;
  logic        dxn, dyn, dwn;
  res_t        res0, res1;

  // Saturating 34-bit to 32-bit conversion.
  function automatic logic [31:0] sat32(input logic [33:0] s);
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      return s[31:0];
    end else if (s[33]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  // Signed add of a start coordinate and a step magnitude.
  function automatic logic [33:0] add_step(input logic [31:0] base, input logic neg,
                                           input logic [31:0] m);
    logic [33:0] d;
    d = {2'b00, m};
    return {{2{base[31]}}, base} + (neg ? (~d + 34'd1) : d);
  endfunction

  logic        s_zero;
  logic [63:0] root_try;
  logic [32:0] ta, tb;
  logic [31:0] mx, my, mw;
  logic [47:0] pfx, pfy, pfw;
  logic [31:0] heading_ext;

  always_comb begin
    s_zero      = (r[31:0] == 32'd0);
    root_try    = r + bitr;
    ta          = {rema[31:0], dla[30]};
    tb          = {remb[31:0], dlb[30]};
    mx          = jb.over ? (s_zero ? 32'd0 : {1'b0, qa}) : jb.vx_mag[31:0];
    my          = jb.over ? (s_zero ? 32'd0 : {1'b0, qb}) : jb.vy_mag[31:0];
    mw          = jb.vw[31] ? (~jb.vw + 32'd1) : jb.vw;
    pfx         = 48'(mx) * 48'(frame_period) + 48'd32768;
    pfy         = 48'(my) * 48'(frame_period) + 48'd32768;
    pfw         = 48'(mw) * 48'(frame_period) + 48'd32768;
    heading_ext = {{12{jb.start_heading[19]}}, jb.start_heading};
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_push   = 1'b0;
    res        = res0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_next = job.over ? ST_NORM : ST_FRAME;
        end
      end
      ST_NORM: begin
        if (!((|a[40:31]) || (|b[40:31]))) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ:    state_next = ST_ROOT;
      ST_ROOT:  if (cnt == 5'd31) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DIV;
      ST_DIV:   if (cnt == 5'd30) state_next = ST_FRAME;
      ST_FRAME: state_next = ST_SUM;
      ST_SUM:   state_next = ST_EMIT0;
      ST_EMIT0: begin
        out_push = !out_full;
        if (!out_full) state_next = ST_EMIT1;
      end
      ST_EMIT1: begin
        out_push = !out_full;
        res      = res1;
        if (!out_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        jb <= job;
        a  <= job.vx_mag;
        b  <= job.vy_mag;
      end
      ST_NORM: begin
        if ((|a[40:31]) || (|b[40:31])) begin
          a <= a >> 1;
          b <= b >> 1;
        end
      end
      ST_SQ: begin
        v    <= 64'(a[30:0]) * 64'(a[30:0]) + 64'(b[30:0]) * 64'(b[30:0]);
        r    <= '0;
        bitr <= 64'd1 << 62;
        cnt  <= '0;
      end
      ST_ROOT: begin
        // One result bit of the integer square root per cycle.
        if (v >= root_try) begin
          v <= v - root_try;
          r <= (r >> 1) + bitr;
        end else begin
          r <= r >> 1;
        end
        bitr <= bitr >> 2;
        cnt  <= cnt + 5'd1;
      end
      ST_SCALE: begin
        {rema, dla} <= {2'b00, 62'(a[30:0]) * 62'(speed_limit)};
        {remb, dlb} <= {2'b00, 62'(b[30:0]) * 62'(speed_limit)};
        cnt         <= '0;
      end
      ST_DIV: begin
        // One quotient bit per cycle for both components.
        dla <= dla << 1;
        dlb <= dlb << 1;
        if (ta >= {1'b0, r[31:0]}) begin
          rema <= ta - {1'b0, r[31:0]};
          qa   <= {qa[29:0], 1'b1};
        end else begin
          rema <= ta;
          qa   <= {qa[29:0], 1'b0};
        end
        if (tb >= {1'b0, r[31:0]}) begin
          remb <= tb - {1'b0, r[31:0]};
          qb   <= {qb[29:0], 1'b1};
        end else begin
          remb <= tb;
          qb   <= {qb[29:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      ST_FRAME: begin
        vxr <= jb.vx_neg ? -mx : mx;
        vyr <= jb.vy_neg ? -my : my;
        dxm <= pfx[47:16];
        dym <= pfy[47:16];
        dwm <= pfw[47:16];
        dxn <= jb.vx_neg;
        dyn <= jb.vy_neg;
        dwn <= jb.vw[31];
      end
      ST_SUM: begin
        res0.pose_x       <= jb.start_x;
        res0.pose_y       <= jb.start_y;
        res0.pose_heading <= heading_ext;
        res0.vel_x        <= jb.start_vel_x;
        res0.vel_y        <= jb.start_vel_y;
        res0.turn_rate    <= jb.start_turn_rate;
        res0.last_step    <= 1'b0;
        res1.pose_x       <= sat32(add_step(jb.start_x, dxn, dxm));
        res1.pose_y       <= sat32(add_step(jb.start_y, dyn, dym));
        res1.pose_heading <= sat32(add_step(heading_ext, dwn, dwm));
        res1.vel_x        <= vxr;
        res1.vel_y        <= vyr;
        res1.turn_rate    <= jb.vw;
        res1.last_step    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The scaled component never exceeds the speed limit.
  a_quot_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FRAME && jb.over && !s_zero) |-> (qa <= speed_limit && qb <= speed_limit))
    else $error("scaled velocity exceeds speed limit");

  // The root fits in 32 bits when scaling begins.
  a_root_width: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE) |-> (r[63:32] == 32'd0))
    else $error("square root wider than 32 bits");

  // The echoed start always precedes the advanced step.
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT1) |-> ($past(state) == ST_EMIT0 || $past(state) == ST_EMIT1))
    else $error("advanced step emitted without echoed start");
endmodule

/* tb/tb_planar_p_gain_velocity_step.sv */
// Testbench for the planar proportional-gain velocity step: directed and random commands.
`timescale 1ns / 1ps

module tb_planar_p_gain_velocity_step;
  import pgv_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  cmd_t cmd = '0;
  logic empty;
  logic pop = 1'b0;
  res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the configuration registers.
  logic [15:0] frame_period_q;
  logic [23:0] linear_gain_q;
  logic [23:0] turn_gain_q;
  logic [30:0] speed_limit_q;
  logic [30:0] turn_rate_limit_q;

  res_t pose_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_results = 1'b0;
  bit burst_sink = 1'b0;

  planar_p_gain_velocity_step dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .empty(empty), .pop(pop), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Product shifted right by 16, rounded to nearest with ties away from zero.
  function automatic longint round_q16(longint a, longint g);
    longint mag;
    longint p;
    mag = (a < 0) ? -a : a;
    p = (mag * g + 64'sd32768) >>> 16;
    return (a < 0) ? -p : p;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Compute the echoed start and the advanced step for one command.
  task automatic predict_steps(input cmd_t c);
    res_t echo;
    res_t adv;
    longint sx, sy, sh, dth, vx, vy, vw, lim, wl;
    longint unsigned ux, uy, a, b, s;
    int k;
    bit over;
    sx = longint'(c.start_x);
    sy = longint'(c.start_y);
    sh = longint'(c.start_heading);
    echo.pose_x = c.start_x;
    echo.pose_y = c.start_y;
    echo.pose_heading = 32'(sh);
    echo.vel_x = c.start_vel_x;
    echo.vel_y = c.start_vel_y;
    echo.turn_rate = c.start_turn_rate;
    echo.last_step = 1'b0;
    pose_queue.push_back(echo);

    dth = longint'(c.target_heading) - sh;
    if (dth < -longint'(PI_Q16)) dth = dth + longint'(TWO_PI_Q16);
    if (dth > longint'(PI_Q16)) dth = dth - longint'(TWO_PI_Q16);
    vx = round_q16(longint'(c.target_x) - sx, longint'(linear_gain_q));
    vy = round_q16(longint'(c.target_y) - sy, longint'(linear_gain_q));
    vw = round_q16(dth, longint'(turn_gain_q));

    lim = longint'(speed_limit_q);
    ux = (vx < 0) ? -vx : vx;
    uy = (vy < 0) ? -vy : vy;
    if (ux > lim || uy > lim) over = 1'b1;
    else over = (ux * ux + uy * uy) > lim * lim;
    if (over) begin
      k = 0;
      while ((ux >> k) >= 64'h8000_0000 || (uy >> k) >= 64'h8000_0000) k++;
      a = ux >> k;
      b = uy >> k;
      s = int_sqrt(a * a + b * b);
      if (s == 0) begin
        a = 0;
        b = 0;
      end else begin
        a = a * lim / s;
        b = b * lim / s;
      end
      vx = (vx < 0) ? -longint'(a) : longint'(a);
      vy = (vy < 0) ? -longint'(b) : longint'(b);
    end
    wl = longint'(turn_rate_limit_q);
    if (vw > wl) vw = wl;
    else if (vw < -wl) vw = -wl;

    adv.pose_x = 32'(clamp32(sx + round_q16(vx, longint'(frame_period_q))));
    adv.pose_y = 32'(clamp32(sy + round_q16(vy, longint'(frame_period_q))));
    adv.pose_heading = 32'(clamp32(sh + round_q16(vw, longint'(frame_period_q))));
    adv.vel_x = 32'(vx);
    adv.vel_y = 32'(vy);
    adv.turn_rate = 32'(vw);
    adv.last_step = 1'b1;
    pose_queue.push_back(adv);
  endtask

  // Offer one command after a random gap and wait until it is taken.
  // Push stays high afterwards so that the next command can follow at once.
  task automatic send_cmd(input cmd_t c, input bit no_gap = 1'b0);
    int gap;
    gap = 0;
    if (!no_gap) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 60);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_steps(c);
  endtask

  // Stop offering commands and wait for every expected result.
  task automatic wait_drained();
    push <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write over the configuration port; only while idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FRAME_PERIOD: frame_period_q = val[15:0];
      REG_LINEAR_GAIN: linear_gain_q = val[23:0];
      REG_TURN_GAIN: turn_gain_q = val[23:0];
      REG_SPEED_LIMIT: speed_limit_q = val[30:0];
      REG_TURN_RATE_LIMIT: turn_rate_limit_q = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] fp, input logic [23:0] lg,
                            input logic [23:0] tg, input logic [30:0] sl,
                            input logic [30:0] tl);
    write_reg(REG_FRAME_PERIOD, {16'd0, fp});
    write_reg(REG_LINEAR_GAIN, {8'd0, lg});
    write_reg(REG_TURN_GAIN, {8'd0, tg});
    write_reg(REG_SPEED_LIMIT, {1'b0, sl});
    write_reg(REG_TURN_RATE_LIMIT, {1'b0, tl});
  endtask

  function automatic logic signed [19:0] rand_heading();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 20'sh80000 + 20'($urandom_range(0, 3));
    if (r == 1) return 20'sh7FFFF - 20'($urandom_range(0, 3));
    return 20'($urandom_range(0, 823550)) - 20'sd411775;
  endfunction

  // Mostly modest distances so that both the limited and unlimited paths appear.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned spread;
    c.start_x = $urandom;
    c.start_y = $urandom;
    c.start_heading = rand_heading();
    c.start_vel_x = $urandom;
    c.start_vel_y = $urandom;
    c.start_turn_rate = $urandom;
    c.target_heading = rand_heading();
    spread = $urandom_range(0, 3);
    if (spread == 0) begin
      c.target_x = $urandom;
      c.target_y = $urandom;
    end else begin
      c.target_x = c.start_x + 32'($signed(18'($urandom)));
      c.target_y = c.start_y + 32'($signed(18'($urandom)));
    end
    if (spread == 1) begin
      c.start_x = 32'($signed(20'($urandom)));
      c.start_y = 32'($signed(20'($urandom)));
      c.target_x = c.start_x + 32'($signed(12'($urandom)));
      c.target_y = c.start_y + 32'($signed(12'($urandom)));
    end
    return c;
  endfunction

  task automatic test_directed();
    cmd_t c;
    c = '0;
    send_cmd(c);
    c.start_x = 32'sh7FFF_FFFF;
    c.start_y = 32'sh8000_0000;
    c.target_x = 32'sh8000_0000;
    c.target_y = 32'sh7FFF_FFFF;
    c.start_heading = 20'sh7FFFF;
    c.target_heading = 20'sh80000;
    c.start_vel_x = 32'sh8000_0000;
    c.start_vel_y = 32'sh7FFF_FFFF;
    c.start_turn_rate = 32'hFFFF_FFFF;
    send_cmd(c);
    c.start_heading = 20'sh80000;
    c.target_heading = 20'sh7FFFF;
    send_cmd(c);
    c = '0;
    c.target_x = 32'sd1000;
    c.target_y = -32'sd1000;
    c.start_heading = -20'sd411775;
    c.target_heading = 20'sd411775;
    send_cmd(c);
    c.start_heading = 20'sd205887;
    c.target_heading = -20'sd205887;
    send_cmd(c);
    c.start_x = 32'sh7FFF_FF00;
    c.target_x = 32'sh7FFF_FFFF;
    send_cmd(c);
    c.start_x = 32'sh8000_0100;
    c.target_x = 32'sh8000_0000;
    send_cmd(c);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    cmd_t c;
    // Zero frame period, zero speed limit, zero turn rate limit.
    set_config(16'd0, 24'hFF_FFFF, 24'hFF_FFFF, 31'd0, 31'd0);
    for (int i = 0; i < 6; i++) send_cmd(rand_cmd());
    wait_drained();
    set_config(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    c = '0;
    c.start_x = 32'sh7FFF_FFFF;
    c.target_x = 32'sh8000_0000;
    c.start_y = 32'sh8000_0000;
    c.target_y = 32'sh7FFF_FFFF;
    c.target_heading = 20'sd205887;
    send_cmd(c);
    for (int i = 0; i < 6; i++) send_cmd(rand_cmd());
    wait_drained();
    set_config(16'd1, 24'd0, 24'd0, 31'd1, 31'd1);
    for (int i = 0; i < 4; i++) send_cmd(rand_cmd());
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_cmd(rand_cmd());
  endtask

  // Hold the result side off while commands keep coming, then drain.
  task automatic test_backpressure();
    hold_results = 1'b1;
    for (int i = 0; i < 30; i++) send_cmd(rand_cmd(), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 4; p++) begin
      set_config(16'($urandom), 24'($urandom_range(0, 24'h03_FFFF)),
                 24'($urandom), 31'($urandom_range(0, 32'h00FF_FFFF)),
                 31'($urandom));
      test_random(100);
      wait_drained();
    end
  endtask

  // Receiver: random pop with stretches of steady popping and long holds.
  initial begin
    int hold;
    int k;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        pop <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        if ($urandom_range(0, 99) == 0) burst_sink = ~burst_sink;
        k = $urandom_range(0, 39);
        if (burst_sink) pop <= 1'b1;
        else if (k == 0) begin
          pop <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end else pop <= (k > 12);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pose_queue.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        res_t e;
        e = pose_queue.pop_front();
        if (res.pose_x !== e.pose_x) begin
          $error("pose_x exp %0d got %0d", e.pose_x, res.pose_x); errors++;
        end
        if (res.pose_y !== e.pose_y) begin
          $error("pose_y exp %0d got %0d", e.pose_y, res.pose_y); errors++;
        end
        if (res.pose_heading !== e.pose_heading) begin
          $error("pose_heading exp %0d got %0d", e.pose_heading, res.pose_heading);
          errors++;
        end
        if (res.vel_x !== e.vel_x) begin
          $error("vel_x exp %0d got %0d", e.vel_x, res.vel_x); errors++;
        end
        if (res.vel_y !== e.vel_y) begin
          $error("vel_y exp %0d got %0d", e.vel_y, res.vel_y); errors++;
        end
        if (res.turn_rate !== e.turn_rate) begin
          $error("turn_rate exp %0d got %0d", e.turn_rate, res.turn_rate); errors++;
        end
        if (res.last_step !== e.last_step) begin
          $error("last_step exp %0b got %0b", e.last_step, res.last_step); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    frame_period_q = FRAME_PERIOD_RST;
    linear_gain_q = LINEAR_GAIN_RST;
    turn_gain_q = TURN_GAIN_RST;
    speed_limit_q = SPEED_LIMIT_RST;
    turn_rate_limit_q = TURN_RATE_LIMIT_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(80);
    wait_drained();
    test_config_extremes();
    test_backpressure();
    test_random_configs();
    set_config(FRAME_PERIOD_RST, LINEAR_GAIN_RST, TURN_GAIN_RST, SPEED_LIMIT_RST,
               TURN_RATE_LIMIT_RST);
    test_random(150);
    wait_drained();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
